// File: sv/gbm8_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes and a helper for the 8x8 GF(2) bit matrix unit.
// No dependencies.
package gbm8_pkg;

  localparam int unsigned MAT_W   = 64;
  localparam int unsigned ROWS    = 8;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 4;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(ROWS);

  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 3'd0,
    OP_TRANSPOSE = 3'd1,
    OP_MUL       = 3'd2,
    OP_ADDMUL    = 3'd3,
    OP_TRSM      = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [MAT_W-1:0] matrix_a;
    logic [MAT_W-1:0] matrix_b;
    logic [MAT_W-1:0] matrix_c;
    logic [IDX_W-1:0] row_first;
    logic [IDX_W-1:0] row_end;
    logic [IDX_W-1:0] col_first;
    logic [IDX_W-1:0] col_end;
  } item_t;

  // Bounds above eight behave as eight.
  function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W-1:0] v);
    return (v > IDX_MAX) ? IDX_MAX : v;
  endfunction

endpackage

// File: sv/gbm8_in_reg.sv
`timescale 1ns / 1ps
// Input register stage: captures one transaction and holds it until the core
// result is taken by the output stage. Depends on gbm8_pkg.
module gbm8_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            drain,
  input  gbm8_pkg::item_t item_in,
  output gbm8_pkg::item_t item,
  output logic            valid
);
  import gbm8_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

// File: sv/gbm8_core.sv
`timescale 1ns / 1ps
// Combinational datapath: add, transpose, multiply, ranged accumulate and
// ranged unit-lower-triangular solve on packed 8x8 bit matrices. Uses gbm8_pkg.
module gbm8_core (
  input  gbm8_pkg::item_t           item,
  output logic [gbm8_pkg::MAT_W-1:0] result
);
  import gbm8_pkg::*;

  logic [ROW_W-1:0] a_row [ROWS];
  logic [ROW_W-1:0] b_row [ROWS];
  logic [ROW_W-1:0] c_row [ROWS];
  logic [ROW_W-1:0] sol_row [ROWS];
  logic [MAT_W-1:0] mac_res, sol_res, tr_res;
  logic [IDX_W-1:0] r0, r1, k0, k1;
  logic [IDX_W-1:0] sr0, sr1;
  logic             plain_mul;

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      a_row[i] = item.matrix_a[i*ROW_W +: ROW_W];
      b_row[i] = item.matrix_b[i*ROW_W +: ROW_W];
      c_row[i] = item.matrix_c[i*ROW_W +: ROW_W];
    end
  end

  // Transpose is pure rewiring.
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      for (int j = 0; j < ROW_W; j++) begin
        tr_res[j*ROW_W + i] = item.matrix_a[i*ROW_W + j];
      end
    end
  end

  // Plain multiply reuses the ranged path with C cleared and full ranges.
  assign plain_mul = (item.operation == OP_MUL);
  assign sr0 = sat_idx(item.row_first);
  assign sr1 = sat_idx(item.row_end);
  assign r0  = plain_mul ? '0 : sr0;
  assign r1  = plain_mul ? IDX_MAX : sr1;
  assign k0  = plain_mul ? '0 : sat_idx(item.col_first);
  assign k1  = plain_mul ? IDX_MAX : sat_idx(item.col_end);

  always_comb begin
    logic [ROW_W-1:0] acc;
    for (int i = 0; i < ROWS; i++) begin
      acc = plain_mul ? '0 : c_row[i];
      if (IDX_W'(i) >= r0 && IDX_W'(i) < r1) begin
        for (int k = 0; k < ROWS; k++) begin
          if (IDX_W'(k) >= k0 && IDX_W'(k) < k1 && a_row[i][k]) begin
            acc = acc ^ b_row[k];
          end
        end
      end
      mac_res[i*ROW_W +: ROW_W] = acc;
    end
  end

  // Forward substitution: row i depends on the already updated rows with lower indices.
  always_comb begin
    logic [ROW_W-1:0] acc;
    for (int i = 0; i < ROWS; i++) begin
      sol_row[i] = c_row[i];
    end
    for (int i = 0; i < ROWS; i++) begin
      acc = sol_row[i];
      for (int k = 0; k < i; k++) begin
        if (IDX_W'(k) >= sr0 && a_row[i][k]) begin
          acc = acc ^ sol_row[k];
        end
      end
      if (IDX_W'(i) >= sr0 && IDX_W'(i) < sr1) begin
        sol_row[i] = acc;
      end
    end
    for (int i = 0; i < ROWS; i++) begin
      sol_res[i*ROW_W +: ROW_W] = sol_row[i];
    end
  end

  always_comb begin
    case (item.operation)
      OP_ADD:       result = item.matrix_a ^ item.matrix_b;
      OP_TRANSPOSE: result = tr_res;
      OP_MUL:       result = mac_res;
      OP_ADDMUL:    result = mac_res;
      OP_TRSM:      result = sol_res;
      default:      result = '0;
    endcase
  end

endmodule

// File: sv/gbm8_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one finished matrix until the downstream side takes
// the transaction. Depends on gbm8_pkg.
module gbm8_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [gbm8_pkg::MAT_W-1:0] data_in,
  input  logic                       ready,
  output logic                       valid,
  output logic [gbm8_pkg::MAT_W-1:0] data,
  output logic                       can_load
);
  import gbm8_pkg::*;

  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_in;
    end
  end

endmodule

// File: sv/gf2_bit_matrix8_unit.sv
`timescale 1ns / 1ps
// 8x8 GF(2) bit matrix unit: input register, one combinational pass, result register.
// A transaction passes the input register, then the result register; one item per cycle while out_ready is high.
// The longest path is the eight-row forward substitution chain in gbm8_core.
// Reset (rst, synchronous): both stages empty, in_ready high, out_valid low.
// Depends on gbm8_pkg, gbm8_in_reg, gbm8_core, gbm8_out_reg.
module gf2_bit_matrix8_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gbm8_pkg::OP_W-1:0]  operation,
  input  logic [gbm8_pkg::MAT_W-1:0] matrix_a,
  input  logic [gbm8_pkg::MAT_W-1:0] matrix_b,
  input  logic [gbm8_pkg::MAT_W-1:0] matrix_c,
  input  logic [gbm8_pkg::IDX_W-1:0] row_first,
  input  logic [gbm8_pkg::IDX_W-1:0] row_end,
  input  logic [gbm8_pkg::IDX_W-1:0] col_first,
  input  logic [gbm8_pkg::IDX_W-1:0] col_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gbm8_pkg::MAT_W-1:0] result_matrix
);
  import gbm8_pkg::*;

  item_t            item_in, item;
  logic             s1_valid;
  logic             s1_load, s1_drain;
  logic             s2_can_load;
  logic [MAT_W-1:0] core_res;

  assign item_in = '{operation: operation, matrix_a: matrix_a, matrix_b: matrix_b,
                     matrix_c: matrix_c, row_first: row_first, row_end: row_end,
                     col_first: col_first, col_end: col_end};

  // Stage 1 moves on whenever the result register can take its output.
  assign s1_drain = s1_valid && s2_can_load;
  assign in_ready = !s1_valid || s2_can_load;
  assign s1_load  = in_valid && in_ready;

  gbm8_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (s1_load),
    .drain   (s1_drain),
    .item_in (item_in),
    .item    (item),
    .valid   (s1_valid)
  );

  gbm8_core u_core (
    .item   (item),
    .result (core_res)
  );

  gbm8_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_drain),
    .data_in  (core_res),
    .ready    (out_ready),
    .valid    (out_valid),
    .data     (result_matrix),
    .can_load (s2_can_load)
  );

  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_can_load |=> out_valid)
    else $error("stage 1 item did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("empty input stage refused a transaction");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_can_load |=> s1_valid && $stable(item))
    else $error("stalled stage 1 item changed");

endmodule
